/* rtl/tlpq_pkg.sv */
package tlpq_pkg;

  localparam int unsigned TLPQ_CAPACITY = 16;

  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned LEVEL_W  = 2;
  localparam int unsigned OCC_W    = 5;
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 40;
  localparam int unsigned NUM_LEVELS  = 3;

  localparam logic       REQ_ENQ = 1'b0;
  localparam logic       REQ_DEQ = 1'b1;

  localparam logic [LEVEL_W-1:0] LVL_LOW  = 2'd0;
  localparam logic [LEVEL_W-1:0] LVL_MED  = 2'd1;
  localparam logic [LEVEL_W-1:0] LVL_HIGH = 2'd2;
  localparam logic [LEVEL_W-1:0] LVL_BAD  = 2'd3;

  typedef enum logic [1:0] {
    STAT_DONE  = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_READ = 2'b10
  } state_e;

endpackage

/* rtl/three_level_priority_queue_core.sv */
// Result path: enqueue, rejected enqueue and dequeue from empty register their result
//   beat directly; a successful dequeue reads the entry memory first (S_READ).
// Throughput: one enqueue per cycle while result beats are taken; no new request is
//   accepted during a successful dequeue until its memory read reaches the output.
// Reset: level counts, pointers and handshake state clear at once; the entry memory
//   is not cleared and needs no clearing pass.
module three_level_priority_queue_core
  import tlpq_pkg::*;
#(
  parameter int unsigned CAPACITY = TLPQ_CAPACITY
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // [31:0] item_value, [33:32] item_level, [39:34] zero
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // [0] req_type
  input  logic                   s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [31:0] out_value, [36:32] occupancy, [37] queue_empty, [39:38] zero
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // [1:0] status
  output logic [1:0]             m_axis_tuser
);

  // Each level is its own ring buffer inside one shared memory; the level
  // selects the region and the ring pointer the slot. Arrival order within a
  // level is preserved, and a dequeue takes the head of the highest non-empty
  // level, which is exactly the front of the stable sorted queue.
  localparam int unsigned PW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW    = $clog2(CAPACITY + 1);
  localparam int unsigned DEPTH = 1 << PW;
  localparam int unsigned AW    = PW + LEVEL_W;
  localparam int unsigned MEM_D = NUM_LEVELS * DEPTH;

  // entry memory, read data registered
  logic [VALUE_W-1:0] mem_q [MEM_D];
  logic [VALUE_W-1:0] rd_data_q;

  state_e state_q, state_d;

  logic [CW-1:0] total_q, total_d;
  logic [CW-1:0] lvl_cnt_q [NUM_LEVELS];
  logic [CW-1:0] lvl_cnt_d [NUM_LEVELS];
  logic [PW-1:0] head_q [NUM_LEVELS];
  logic [PW-1:0] head_d [NUM_LEVELS];
  logic [PW-1:0] tail_q [NUM_LEVELS];
  logic [PW-1:0] tail_d [NUM_LEVELS];

  // output register
  logic               m_valid_q, m_valid_d;
  status_e            m_status_q, m_status_d;
  logic [VALUE_W-1:0] m_value_q, m_value_d;
  logic [OCC_W-1:0]   m_occ_q, m_occ_d;
  logic               m_empty_q, m_empty_d;

  logic               accept;
  logic               req;
  logic [VALUE_W-1:0] in_value;
  logic [LEVEL_W-1:0] in_level;
  logic [LEVEL_W-1:0] enq_lvl;
  logic [LEVEL_W-1:0] deq_lvl;
  logic               wr_en;
  logic               rd_en;
  logic [AW-1:0]      wr_addr;
  logic [AW-1:0]      rd_addr;
  logic [31:0]        occ_wide;

  assign req      = s_axis_tuser;
  assign in_value = s_axis_tdata[VALUE_W-1:0];
  assign in_level = s_axis_tdata[VALUE_W +: LEVEL_W];

  // one item in flight; a waiting result beat does not block as long as it
  // leaves in the same cycle
  assign s_axis_tready = (state_q == S_IDLE) && (!m_valid_q || m_axis_tready);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // level three folds onto high
  assign enq_lvl = (in_level == LVL_BAD) ? LVL_HIGH : in_level;

  always_comb begin
    priority if (lvl_cnt_q[LVL_HIGH] != '0) begin
      deq_lvl = LVL_HIGH;
    end else if (lvl_cnt_q[LVL_MED] != '0) begin
      deq_lvl = LVL_MED;
    end else begin
      deq_lvl = LVL_LOW;
    end
  end

  assign wr_addr = {enq_lvl, tail_q[enq_lvl]};
  assign rd_addr = {deq_lvl, head_q[deq_lvl]};

  always_comb begin
    state_d    = state_q;
    total_d    = total_q;
    lvl_cnt_d  = lvl_cnt_q;
    head_d     = head_q;
    tail_d     = tail_q;
    wr_en      = 1'b0;
    rd_en      = 1'b0;
    m_status_d = m_status_q;
    m_value_d  = m_value_q;

    m_valid_d = m_valid_q && !m_axis_tready;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          m_value_d = '0;
          if (req == REQ_ENQ) begin
            if (total_q == CW'(CAPACITY)) begin
              m_status_d = STAT_FULL;
            end else begin
              m_status_d         = STAT_DONE;
              wr_en              = 1'b1;
              tail_d[enq_lvl]    = tail_q[enq_lvl] + 1'b1;
              lvl_cnt_d[enq_lvl] = lvl_cnt_q[enq_lvl] + 1'b1;
              total_d            = total_q + 1'b1;
            end
            m_valid_d = 1'b1;
          end else begin
            if (total_q == '0) begin
              m_status_d = STAT_EMPTY;
              m_valid_d  = 1'b1;
            end else begin
              // value arrives from memory next cycle
              m_status_d         = STAT_DONE;
              rd_en              = 1'b1;
              head_d[deq_lvl]    = head_q[deq_lvl] + 1'b1;
              lvl_cnt_d[deq_lvl] = lvl_cnt_q[deq_lvl] - 1'b1;
              total_d            = total_q - 1'b1;
              m_valid_d          = 1'b0;
              state_d            = S_READ;
            end
          end
        end
      end
      S_READ: begin
        // output register is free here: it was empty or drained at accept
        m_value_d = rd_data_q;
        m_valid_d = 1'b1;
        state_d   = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // occupancy is the low bits of the count after this item
  assign occ_wide  = 32'(total_d);
  assign m_occ_d   = accept ? occ_wide[OCC_W-1:0] : m_occ_q;
  assign m_empty_d = accept ? (total_d == '0) : m_empty_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      total_q   <= '0;
      m_valid_q <= 1'b0;
      for (int i = 0; i < NUM_LEVELS; i++) begin
        lvl_cnt_q[i] <= '0;
        head_q[i]    <= '0;
        tail_q[i]    <= '0;
      end
    end else begin
      state_q   <= state_d;
      total_q   <= total_d;
      m_valid_q <= m_valid_d;
      lvl_cnt_q <= lvl_cnt_d;
      head_q    <= head_d;
      tail_q    <= tail_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_status_q <= m_status_d;
    m_value_q  <= m_value_d;
    m_occ_q    <= m_occ_d;
    m_empty_q  <= m_empty_d;
  end

  // entry memory: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= in_value;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_status_q;
  assign m_axis_tdata  = {(OUT_TDATA_W - VALUE_W - OCC_W - 1)'(0), m_empty_q, m_occ_q,
                          m_value_q};

endmodule
